// ===== hw/rtl/ufwf_pkg.sv =====
// Shared types and constants for the union-find wall filter.
// Used by every module of the block; depends on nothing.
package ufwf_pkg;

   localparam int CELL_W     = 12;
   localparam int RANK_W     = 4;
   localparam int DIM_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int CELL_LIMIT = 1 << CELL_W;

   localparam int MAX_ROW_COUNT_DEF = 64;
   localparam int MAX_COL_COUNT_DEF = 64;

   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_WALL  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_CLEARED = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      logic              action;
      logic [CELL_W-1:0] cell_a;
      logic [CELL_W-1:0] cell_b;
   } req_type;

   typedef struct packed {
      logic       wall_removed;
      status_type status;
   } rsp_type;

   // one table word: rank next to parent pointer
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [CELL_W-1:0] parent;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [CELL_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [CELL_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== hw/rtl/ufwf_table.sv =====
// Disjoint-set table: one synchronous memory of parent/rank words.
// One write and one registered read per cycle. Depends on ufwf_pkg.
module ufwf_table #(
   parameter int DEPTH = ufwf_pkg::CELL_LIMIT
) (
   input  logic                  clock,
   input  ufwf_pkg::mem_req_type mem_req,
   output ufwf_pkg::entry_type   rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   ufwf_pkg::entry_type mem [DEPTH];
   ufwf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[ADDR_W-1:0]] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr[ADDR_W-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ufwf_ctrl.sv =====
// Sequencer for the wall filter: clearing pass, two root walks, linking,
// and the result register. Depends on ufwf_pkg; drives ufwf_table.
module ufwf_ctrl #(
   parameter int DEPTH = ufwf_pkg::CELL_LIMIT,
   parameter int CNT_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ufwf_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ufwf_pkg::rsp_type     rsp_data,
   input  logic [CNT_W-1:0]      cell_count,
   output ufwf_pkg::mem_req_type mem_req,
   input  ufwf_pkg::entry_type   rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_CHECK  = 8'b0000_0100,
      ST_FIND_A = 8'b0000_1000,
      ST_FIND_B = 8'b0001_0000,
      ST_BUMP   = 8'b0010_0000,
      ST_REPLY  = 8'b0100_0000,
      ST_SPARE  = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   ufwf_pkg::req_type               req_ff, req_in;
   logic [ufwf_pkg::CELL_W-1:0]     cur_ff, cur_in;
   logic [ufwf_pkg::CELL_W-1:0]     root_a_ff, root_a_in;
   logic [ufwf_pkg::RANK_W-1:0]     rank_a_ff, rank_a_in;
   ufwf_pkg::rsp_type               result_ff, result_in;
   logic [ADDR_W-1:0]               clr_cnt_ff, clr_cnt_in;
   logic                            clr_reply_ff, clr_reply_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ufwf_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                            out_free;
   logic                            out_of_range;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign out_of_range = (32'(req_ff.cell_a) >= 32'(cell_count)) ||
                         (32'(req_ff.cell_b) >= 32'(cell_count));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      root_a_in    = root_a_ff;
      rank_a_in    = rank_a_ff;
      result_in    = result_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_reply_in = clr_reply_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      mem_req         = '0;
      mem_req.wr_addr = cur_ff;
      mem_req.rd_addr = cur_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = ufwf_pkg::CELL_W'(clr_cnt_ff);
            mem_req.wr_data.parent = ufwf_pkg::CELL_W'(clr_cnt_ff);
            mem_req.wr_data.rank   = '0;
            clr_cnt_in             = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               result_in.wall_removed = 1'b0;
               result_in.status       = ufwf_pkg::STATUS_CLEARED;
               state_in               = clr_reply_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.action == ufwf_pkg::ACT_START) begin
                  clr_cnt_in   = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (out_of_range) begin
               result_in.wall_removed = 1'b0;
               result_in.status       = ufwf_pkg::STATUS_RANGE;
               state_in               = ST_REPLY;
            end else begin
               mem_req.rd_addr = req_ff.cell_a;
               cur_in          = req_ff.cell_a;
               state_in        = ST_FIND_A;
            end
         end
         ST_FIND_A: begin
            // rd_data holds the word of cur_ff; follow the pointer one hop a cycle
            if (rd_data.parent == cur_ff) begin
               root_a_in       = cur_ff;
               rank_a_in       = rd_data.rank;
               mem_req.rd_addr = req_ff.cell_b;
               cur_in          = req_ff.cell_b;
               state_in        = ST_FIND_B;
            end else begin
               mem_req.rd_addr = rd_data.parent;
               cur_in          = rd_data.parent;
            end
         end
         ST_FIND_B: begin
            if (rd_data.parent == cur_ff) begin
               if (cur_ff == root_a_ff) begin
                  result_in.wall_removed = 1'b0;
                  result_in.status       = ufwf_pkg::STATUS_DONE;
                  state_in               = ST_REPLY;
               end else begin
                  result_in.wall_removed = 1'b1;
                  result_in.status       = ufwf_pkg::STATUS_DONE;
                  mem_req.wr_en          = 1'b1;
                  if (rank_a_ff < rd_data.rank) begin
                     mem_req.wr_addr        = root_a_ff;
                     mem_req.wr_data.parent = cur_ff;
                     mem_req.wr_data.rank   = rank_a_ff;
                     state_in               = ST_REPLY;
                  end else begin
                     mem_req.wr_addr        = cur_ff;
                     mem_req.wr_data.parent = root_a_ff;
                     mem_req.wr_data.rank   = rd_data.rank;
                     // equal ranks: root a grows by one
                     state_in = (rank_a_ff == rd_data.rank) ? ST_BUMP : ST_REPLY;
                  end
               end
            end else begin
               mem_req.rd_addr = rd_data.parent;
               cur_in          = rd_data.parent;
            end
         end
         ST_BUMP: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = root_a_ff;
            mem_req.wr_data.parent = root_a_ff;
            mem_req.wr_data.rank   = (rank_a_ff == ufwf_pkg::RANK_MAX) ?
                                     rank_a_ff : rank_a_ff + 1'b1;
            state_in               = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      root_a_ff   <= root_a_in;
      rank_a_ff   <= rank_a_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/union_find_wall_filter.sv =====
// Top level of the union-find wall filter: grid registers, cell count,
// sequencer and table. Depends on ufwf_pkg, ufwf_table and ufwf_ctrl.
//
// Kruskal maze filter. A start request (action 0) resets every cell to its
// own set and answers status 1; a wall request (action 1) answers status 2
// if either cell is at or beyond rows*cols, otherwise status 0 with
// wall_removed set when the two sets were merged. One request is in work
// at a time; a result waits in an output register so the next request is
// taken while it is stalled. The table is one single-port-read memory, so
// a wall first walks to the root of cell_a, then to the root of cell_b, and
// on equal ranks adds a rank update step; out-of-range walls skip both
// walks. A start request and reset both run a clearing pass over
// min(MAX_ROW_COUNT*MAX_COL_COUNT, 4096) entries, one entry a cycle, with
// req_stall high. Grid registers are written via the csr port; the user must
// do so only while no request is in work; the block does not enforce this.
module union_find_wall_filter #(
   parameter int MAX_ROW_COUNT = ufwf_pkg::MAX_ROW_COUNT_DEF,
   parameter int MAX_COL_COUNT = ufwf_pkg::MAX_COL_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ufwf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ufwf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [ufwf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ufwf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CELL_MAX = MAX_ROW_COUNT * MAX_COL_COUNT;
   localparam int DEPTH    = (CELL_MAX < ufwf_pkg::CELL_LIMIT) ? CELL_MAX
                                                               : ufwf_pkg::CELL_LIMIT;
   localparam int ROW_W    = $clog2(MAX_ROW_COUNT + 1);
   localparam int COL_W    = $clog2(MAX_COL_COUNT + 1);
   localparam int CNT_W    = $clog2(CELL_MAX + 1);

   logic [ufwf_pkg::DIM_W-1:0] rows_ff, rows_in;
   logic [ufwf_pkg::DIM_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]           rows_use;
   logic [COL_W-1:0]           cols_use;
   logic [CNT_W-1:0]           cells_use;

   ufwf_pkg::mem_req_type mem_req;
   ufwf_pkg::entry_type   rd_data;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ufwf_pkg::CSR_GRID_ROWS: rows_in = csr_wdata;
            ufwf_pkg::CSR_GRID_COLS: cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // zero counts as one, anything above the maximum as the maximum
   always_comb begin
      if (rows_ff == '0) begin
         rows_use = ROW_W'(1);
      end else if (32'(rows_ff) > MAX_ROW_COUNT) begin
         rows_use = ROW_W'(MAX_ROW_COUNT);
      end else begin
         rows_use = ROW_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_use = COL_W'(1);
      end else if (32'(cols_ff) > MAX_COL_COUNT) begin
         cols_use = COL_W'(MAX_COL_COUNT);
      end else begin
         cols_use = COL_W'(cols_ff);
      end
      cells_use = CNT_W'(rows_use) * CNT_W'(cols_use);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ufwf_pkg::DIM_W'(1);
         cols_ff <= ufwf_pkg::DIM_W'(1);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   ufwf_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .cell_count (cells_use),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   ufwf_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== hw/rtl/ufwf_checker.sv =====
// Port-level checks for the union-find wall filter, bound to the top level.
// Depends on ufwf_pkg.
module ufwf_assert (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ufwf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ufwf_pkg::rsp_type rsp_data
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // one request at a time: the sequencer leaves idle on every accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("request accepted while another is in work");

   // a start request runs the clearing pass before anything else is taken
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.action == ufwf_pkg::ACT_START) |-> ##3 req_stall)
      else $error("request taken during clearing pass");

   // a new result only appears while the sequencer was busy
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind union_find_wall_filter ufwf_assert u_ufwf_assert (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/ufwf_checker.sv =====
`timescale 1ns / 1ps
// Checker for the union-find wall filter: watches the request, response and csr ports,
// keeps its own disjoint-set table and grid size, and compares every response in order.
// Depends on ufwf_pkg.
module ufwf_checker
   import ufwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  drain_done,
   output int                    fail_count
);

   localparam int ROW_LIMIT  = MAX_ROW_COUNT_DEF;
   localparam int COL_LIMIT  = MAX_COL_COUNT_DEF;
   localparam int REPORT_MAX = 10;

   logic [CELL_W-1:0] parent_mem [CELL_LIMIT];
   logic [RANK_W-1:0] rank_mem [CELL_LIMIT];
   logic [DIM_W-1:0]  rows_cfg;
   logic [DIM_W-1:0]  cols_cfg;
   rsp_type           expected_rsp_q[$];
   int                error_count = 0;
   int                waiting_count = 0;

   // leftover expectations only count once the bench says the run has drained
   assign fail_count = error_count + (drain_done ? waiting_count : 0);

   function automatic void clear_sets();
      for (int i = 0; i < CELL_LIMIT; i++) begin
         parent_mem[i] = CELL_W'(i);
         rank_mem[i]   = '0;
      end
   endfunction

   function automatic int clamp_dim(input int value, input int limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic logic [CELL_W-1:0] root_of(input logic [CELL_W-1:0] start_node);
      logic [CELL_W-1:0] node;
      int                hops;
      node = start_node;
      hops = 0;
      while (parent_mem[node] != node && hops < CELL_LIMIT) begin
         node = parent_mem[node];
         hops++;
      end
      return node;
   endfunction

   // applies one request to the shadow table and returns the response it must cause
   function automatic rsp_type apply_request(input req_type item);
      rsp_type           res;
      int                cells;
      logic [CELL_W-1:0] root_a;
      logic [CELL_W-1:0] root_b;
      res.wall_removed = 1'b0;
      res.status       = STATUS_DONE;
      if (item.action == ACT_START) begin
         clear_sets();
         res.status = STATUS_CLEARED;
         return res;
      end
      cells = clamp_dim(int'(rows_cfg), ROW_LIMIT) * clamp_dim(int'(cols_cfg), COL_LIMIT);
      if (int'(item.cell_a) >= cells || int'(item.cell_b) >= cells) begin
         res.status = STATUS_RANGE;
         return res;
      end
      root_a = root_of(item.cell_a);
      root_b = root_of(item.cell_b);
      if (root_a == root_b) return res;
      if (rank_mem[root_a] < rank_mem[root_b]) begin
         parent_mem[root_a] = root_b;
      end else if (rank_mem[root_a] > rank_mem[root_b]) begin
         parent_mem[root_b] = root_a;
      end else begin
         parent_mem[root_b] = root_a;
         if (rank_mem[root_a] != RANK_MAX) rank_mem[root_a] = rank_mem[root_a] + 1'b1;
      end
      res.wall_removed = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_sets();
         rows_cfg = DIM_W'(1);
         cols_cfg = DIM_W'(1);
         expected_rsp_q.delete();
         waiting_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_ROWS: rows_cfg = csr_wdata[DIM_W-1:0];
               CSR_GRID_COLS: cols_cfg = csr_wdata[DIM_W-1:0];
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(apply_request(req_data));
            waiting_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               if (error_count < REPORT_MAX)
                  $display("[%0t] unexpected response: removed=%0d status=%0d", $realtime,
                           rsp_data.wall_removed, rsp_data.status);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               waiting_count--;
               if (rsp_data.wall_removed !== want.wall_removed ||
                   rsp_data.status !== want.status) begin
                  if (error_count < REPORT_MAX) begin
                     $display("[%0t] mismatch: expected removed=%0d status=%0d",
                              $realtime, want.wall_removed, want.status);
                     $display("         got removed=%0d status=%0d",
                              rsp_data.wall_removed, rsp_data.status);
                  end
                  error_count++;
               end
            end
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the union-find wall filter bench: clock, reset, csr setup and request stimulus.
// Depends on ufwf_pkg, union_find_wall_filter and ufwf_checker.
module testbench;
   import ufwf_pkg::*;

   localparam int RANDOM_ITEMS   = 1400;
   localparam int CALM_ITEMS     = 150;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 64;
   localparam int ROW_LIMIT      = MAX_ROW_COUNT_DEF;
   localparam int COL_LIMIT      = MAX_COL_COUNT_DEF;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  drain_done;
   int                    fail_count;

   int sent_count = 0;
   int got_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   int setting_count = 0;
   int start_count = 0;
   int directed_count = 0;
   bit idle_on = 1'b0;

   union_find_wall_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ufwf_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .drain_done (drain_done),
      .fail_count (fail_count)
   );

   always #2 clock = ~clock;

   // response back-pressure in random bursts while idle_on is set
   always @(posedge clock) begin
      if (!idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) got_count <= got_count + 1;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic action, input int a, input int b);
      req_type item;
      item.action = action;
      item.cell_a = CELL_W'(a);
      item.cell_b = CELL_W'(b);
      return item;
   endfunction

   function automatic int clamp_dim(input int value, input int limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // valid stays high across back-to-back requests; this task only drops it for a gap
   task automatic send_request(input req_type item);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (item.action == ACT_START) start_count++;
      if (sent_count >= directed_count + RANDOM_ITEMS - CALM_ITEMS && directed_count > 0)
         idle_on = 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
   endtask

   task automatic write_grid(input int rows_raw, input int cols_raw);
      bit rows_first;
      rows_first = $urandom_range(0, 1);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= rows_first ? CSR_GRID_ROWS : CSR_GRID_COLS;
      csr_wdata <= CSR_DATA_W'(rows_first ? rows_raw : cols_raw);
      @(posedge clock);
      csr_index <= rows_first ? CSR_GRID_COLS : CSR_GRID_ROWS;
      csr_wdata <= CSR_DATA_W'(rows_first ? cols_raw : rows_raw);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      setting_count++;
   endtask

   // off-pattern requests: wild indices, boundary cells, self walls, far pairs, rare start
   function automatic req_type make_noise(input int cells);
      int a;
      int b;
      a = $urandom_range(0, cells - 1);
      b = $urandom_range(0, cells - 1);
      case ($urandom_range(0, 5))
         0: begin
            a = $urandom_range(0, CELL_LIMIT - 1);
            b = $urandom_range(0, CELL_LIMIT - 1);
         end
         1: a = (cells < CELL_LIMIT) ? cells : cells - 1;
         2: b = (cells < CELL_LIMIT) ? $urandom_range(cells, CELL_LIMIT - 1) : cells - 1;
         3: b = a;
         4: ;
         default: begin
            if ($urandom_range(0, 19) == 0)
               return make_req(ACT_START, $urandom_range(0, CELL_LIMIT - 1),
                               $urandom_range(0, CELL_LIMIT - 1));
         end
      endcase
      return make_req(ACT_WALL, a, b);
   endfunction

   task automatic send_wall_with_noise(input req_type item, input int cells);
      if ($urandom_range(0, 5) == 0) send_request(make_noise(cells));
      send_request(item);
   endtask

   task automatic run_maze();
      int      rows_raw;
      int      cols_raw;
      int      rows;
      int      cols;
      int      cells;
      int      band;
      int      a;
      int      j;
      req_type wall_q[$];
      req_type tmp;
      case ($urandom_range(0, 9))
         0, 1: begin
            rows_raw = $urandom_range(0, 1) ? ROW_LIMIT : $urandom_range(ROW_LIMIT + 1, 127);
            cols_raw = $urandom_range(0, 1) ? COL_LIMIT : $urandom_range(COL_LIMIT + 1, 127);
         end
         2: begin
            case ($urandom_range(0, 3))
               0: rows_raw = 0;
               1: rows_raw = 1;
               2: rows_raw = ROW_LIMIT;
               default: rows_raw = 127;
            endcase
            case ($urandom_range(0, 3))
               0: cols_raw = 0;
               1: cols_raw = 1;
               2: cols_raw = COL_LIMIT;
               default: cols_raw = 127;
            endcase
         end
         default: begin
            rows_raw = $urandom_range(1, 8);
            cols_raw = $urandom_range(1, 8);
         end
      endcase
      if (directed_count > 0 && sent_count < directed_count + RANDOM_ITEMS - CALM_ITEMS)
         idle_on = ($urandom_range(0, 3) != 0);
      write_grid(rows_raw, cols_raw);
      rows  = clamp_dim(rows_raw, ROW_LIMIT);
      cols  = clamp_dim(cols_raw, COL_LIMIT);
      cells = rows * cols;
      // now and then keep the old table across a grid change
      if ($urandom_range(0, 3) != 0)
         send_request(make_req(ACT_START, $urandom_range(0, CELL_LIMIT - 1),
                               $urandom_range(0, CELL_LIMIT - 1)));
      if (cells <= 128) begin
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               a = r * cols + c;
               if (c + 1 < cols) wall_q.push_back(make_req(ACT_WALL, a, a + 1));
               if (r + 1 < rows) wall_q.push_back(make_req(ACT_WALL, a, a + cols));
            end
         end
         for (int i = wall_q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = wall_q[i];
            wall_q[i] = wall_q[j];
            wall_q[j] = tmp;
         end
      end else begin
         // dense band of rows so sets grow deep instead of staying pairs
         band = $urandom_range(2, rows);
         for (int i = 0; i < 100; i++) begin
            a = $urandom_range(0, band * cols - 1);
            if ($urandom_range(0, 1) && (a % cols) + 1 < cols)
               wall_q.push_back(make_req(ACT_WALL, a, a + 1));
            else if (a + cols < cells)
               wall_q.push_back(make_req(ACT_WALL, a, a + cols));
            else
               wall_q.push_back(make_req(ACT_WALL, a, a - 1 < 0 ? 0 : a - 1));
         end
      end
      foreach (wall_q[i]) begin
         tmp = wall_q[i];
         if ($urandom_range(0, 1)) begin
            tmp.cell_a = wall_q[i].cell_b;
            tmp.cell_b = wall_q[i].cell_a;
         end
         send_wall_with_noise(tmp, cells);
      end
      if (cells == 1) begin
         for (int i = 0; i < 6; i++) send_request(make_noise(cells));
      end
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_GRID_ROWS;
      csr_wdata  = '0;
      drain_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // walls before any start, on the reset 1x1 grid
      send_request(make_req(ACT_WALL, 0, 0));
      send_request(make_req(ACT_WALL, 0, 1));
      send_request(make_req(ACT_WALL, 4095, 4095));
      send_request(make_req(ACT_WALL, 1, 0));
      // zero sizes read as one
      write_grid(0, 0);
      send_request(make_req(ACT_WALL, 0, 0));
      send_request(make_req(ACT_WALL, 0, 1));
      // oversize reads as the maximum grid
      write_grid(127, 127);
      send_request(make_req(ACT_WALL, 4095, 4094));
      send_request(make_req(ACT_WALL, 4094, 4095));
      send_request(make_req(ACT_WALL, 4095, 0));
      send_request(make_req(ACT_WALL, 0, 4095));
      send_request(make_req(ACT_WALL, 0, 64));
      send_request(make_req(ACT_START, 4095, 4095));
      send_request(make_req(ACT_WALL, 4095, 0));
      send_request(make_req(ACT_WALL, 7, 7));
      send_request(make_req(ACT_WALL, 1, 4000));
      send_request(make_req(ACT_WALL, 4000, 1));
      write_grid(2, 3);
      send_request(make_req(ACT_WALL, 5, 6));
      send_request(make_req(ACT_WALL, 6, 5));
      send_request(make_req(ACT_WALL, 5, 0));
      send_request(make_req(ACT_WALL, 0, 5));
      send_request(make_req(ACT_START, 0, 0));
      send_request(make_req(ACT_WALL, 0, 1));
      directed_count = sent_count;

      while (sent_count < directed_count + RANDOM_ITEMS) run_maze();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      @(posedge clock);
      $display("Covered %0d requests (%0d starts) over %0d grid settings,", sent_count,
               start_count, setting_count);
      $display("including shuffled full mazes, dense large-grid bands and off-grid noise.");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d failures", fail_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ufwf_pkg.sv
hw/rtl/ufwf_table.sv
hw/rtl/ufwf_ctrl.sv
hw/rtl/union_find_wall_filter.sv
hw/rtl/ufwf_checker.sv
bench/ufwf_checker.sv
bench/testbench.sv
